// ----- rtl/led_matrix_pixel_scanner_core_defines.svh -----
// Assertion macros shared by the LED matrix pixel scanner modules.
`ifndef LED_MATRIX_PIXEL_SCANNER_CORE_DEFINES_SVH
`define LED_MATRIX_PIXEL_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LMPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmps check failed in the same cycle");

// Next-cycle implication, checked on every rising edge outside reset.
`define LMPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmps check failed one cycle later");

`endif

// ----- rtl/lmps_pkg.sv -----
// Package with the beat types, function codes and scan map of the pixel scanner.
`default_nettype none
package lmps_pkg;

  // Function codes carried in the func field.
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_SET   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_LOAD  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  // Image and drive matrix geometry.
  localparam int PixCount = 25;
  localparam int MatCols  = 9;
  localparam int MapSize  = 27;

  // Image pixel shown at each drive matrix position, row-major 3 x 9.
  localparam logic [4:0] SCAN_MAP [0:MapSize-1] = '{
    5'd0,  5'd2,  5'd4,  5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd11,
    5'd14, 5'd10, 5'd12, 5'd1,  5'd3,  5'd23, 5'd21, 5'd0,  5'd0,
    5'd22, 5'd24, 5'd20, 5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd13
  };

  // One input beat.
  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  pixel_col;
    logic [2:0]  pixel_row;
    logic        pixel_on;
    logic [4:0]  pixel_number;
    logic [24:0] image_word;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic       drive_active;
    logic [1:0] drive_row;
    logic [3:0] drive_col;
    logic       pixel_value;
    logic       display_running;
  } rsp_t;

  // Operation handed to the state modules when an item is executed.
  typedef struct packed {
    logic       fire;
    logic [2:0] func;
  } op_t;

  // Drive outputs produced by the scan unit.
  typedef struct packed {
    logic       active;
    logic [1:0] row;
    logic [3:0] col;
  } drive_t;

  // Image pixel at a matrix position; positions outside the map show pixel 0.
  function automatic logic [4:0] scan_pixel(input logic [1:0] row, input logic [3:0] col);
    logic [5:0] pos;
    pos = 6'({4'd0, row} * 6'(MatCols)) + {2'd0, col};
    if (pos < 6'(MapSize)) begin
      return SCAN_MAP[pos[4:0]];
    end
    return 5'd0;
  endfunction

  // One-hot mask for a pixel index, empty when the index is off the image.
  function automatic logic [24:0] pix_mask(input logic [5:0] idx);
    if (idx < 6'(PixCount)) begin
      return 25'd1 << idx;
    end
    return '0;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/led_matrix_pixel_scanner_core.sv -----
// An accepted beat is held in the input register, then its result in the result register.
// Throughput: one item per cycle when not stalled; update and map lookup fit in one stage.
// Both registers move together, so a stalled result holds the input beat behind it.
// Reset (rst, synchronous): image cleared, scan at matrix row 0 column 0, pipeline empty.
// Top level of the LED matrix pixel scanner.
`default_nettype none
module led_matrix_pixel_scanner_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lmps_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lmps_pkg::rsp_t  rsp
);

  logic             held_valid;
  lmps_pkg::req_t   held;
  logic             out_free;
  lmps_pkg::op_t    op;
  logic [24:0]      image;
  logic             pixel_value;
  logic             running_next;
  lmps_pkg::drive_t drive;
  lmps_pkg::rsp_t   rsp_next;

  // The result register is free when empty or being taken this cycle.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = held_valid && !out_free;
  assign op.fire   = held_valid && out_free;
  assign op.func   = held.func;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= req;
    end
  end

  lmps_image u_image (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .item         (held),
    .image        (image),
    .pixel_value  (pixel_value),
    .running_next (running_next)
  );

  lmps_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .image (image),
    .drive (drive)
  );

  // Result beat assembly.
  always_comb begin
    rsp_next.drive_active    = drive.active;
    rsp_next.drive_row       = drive.row;
    rsp_next.drive_col       = drive.col;
    rsp_next.pixel_value     = pixel_value;
    rsp_next.display_running = running_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.fire) begin
      rsp <= rsp_next;
    end
  end

`include "led_matrix_pixel_scanner_core_defines.svh"

  `LMPS_ASSERT_NOW(a_drive_needs_image, rsp_valid && rsp.drive_active, rsp.display_running)
  `LMPS_ASSERT_NOW(a_drive_on_matrix, rsp_valid && rsp.drive_active,
                   (rsp.drive_col <= 4'd8) && !(rsp.drive_row == 2'd1 && rsp.drive_col > 4'd6))
  `LMPS_ASSERT_NOW(a_read_not_drive, rsp_valid && rsp.pixel_value, !rsp.drive_active)

endmodule
`default_nettype wire

// ----- rtl/lmps_image.sv -----
// Image register of the pixel scanner with its pixel write, load and read logic.
`default_nettype none
module lmps_image (
  input  logic               clk,
  input  logic               rst,
  input  lmps_pkg::op_t      op,
  input  lmps_pkg::req_t     item,
  output logic [24:0]        image,
  output logic               pixel_value,
  output logic               running_next
);

  logic [24:0] image_next;
  logic [5:0]  lin;
  logic [24:0] lin_mask;
  logic [24:0] num_mask;

  // Linear pixel index from image column and row.
  assign lin      = 6'({3'd0, item.pixel_row} * 6'd5) + {3'd0, item.pixel_col};
  assign lin_mask = lmps_pkg::pix_mask(lin);
  assign num_mask = lmps_pkg::pix_mask({1'b0, item.pixel_number});

  // Image update for the executed function.
  always_comb begin
    image_next = image;
    case (op.func)
      lmps_pkg::FUNC_WRITE: begin
        image_next = item.pixel_on ? (image | lin_mask) : (image & ~lin_mask);
      end
      lmps_pkg::FUNC_SET:   image_next = image | num_mask;
      lmps_pkg::FUNC_CLEAR: image_next = image & ~num_mask;
      lmps_pkg::FUNC_LOAD:  image_next = item.image_word;
      default:              image_next = image;
    endcase
  end

  // Read-back and running flag seen by the result beat.
  assign pixel_value  = (op.func == lmps_pkg::FUNC_READ) && (|(image & lin_mask));
  assign running_next = |image_next;

  // The image changes only when an item executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image <= '0;
    end else if (op.fire) begin
      image <= image_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lmps_scan.sv -----
// Scan position register and matrix lookup of the pixel scanner.
`default_nettype none
module lmps_scan (
  input  logic                clk,
  input  logic                rst,
  input  lmps_pkg::op_t       op,
  input  logic [24:0]         image,
  output lmps_pkg::drive_t    drive
);

  logic [1:0] scan_row;
  logic [3:0] scan_col;
  logic [1:0] scan_row_next;
  logic [3:0] scan_col_next;
  logic       advance;
  logic       row_end;
  logic [4:0] pix;
  logic       lit;

  // Ticks only move the scan while the image shows something.
  assign advance = op.fire && (op.func == lmps_pkg::FUNC_TICK) && (|image);

  // Next scan position: short middle row, wrap after the last column and row.
  assign row_end = ((scan_row == 2'd1) && (scan_col == 4'd6)) || (scan_col >= 4'd8) ||
                   (scan_row == 2'd3);
  always_comb begin
    if (row_end) begin
      scan_row_next = (scan_row >= 2'd2) ? 2'd0 : scan_row + 2'd1;
      scan_col_next = 4'd0;
    end else begin
      scan_row_next = scan_row;
      scan_col_next = scan_col + 4'd1;
    end
  end

  // Pixel shown at the new position and whether it is lit.
  assign pix = lmps_pkg::scan_pixel(scan_row_next, scan_col_next);
  assign lit = image[pix];

  // Drive outputs, all zero unless a lit pixel is shown.
  always_comb begin
    drive.active = advance && lit;
    drive.row    = drive.active ? scan_row_next : 2'd0;
    drive.col    = drive.active ? scan_col_next : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= 2'd0;
      scan_col <= 4'd0;
    end else if (advance) begin
      scan_row <= scan_row_next;
      scan_col <= scan_col_next;
    end
  end

`include "led_matrix_pixel_scanner_core_defines.svh"

  `LMPS_ASSERT_NOW(a_scan_row_range, 1'b1, scan_row <= 2'd2)
  `LMPS_ASSERT_NOW(a_scan_short_row, scan_row == 2'd1, scan_col <= 4'd6)
  `LMPS_ASSERT_NEXT(a_scan_hold, !advance, $stable(scan_row) && $stable(scan_col))

endmodule
`default_nettype wire
